// ----- src/reaction_diffusion_cell_update_assert.svh -----
// Assertion macros for the checker of the reaction-diffusion cell update.
// Needs a clk_i and an rst_ni in the scope where a macro is used.
`ifndef REACTION_DIFFUSION_CELL_UPDATE_ASSERT_SVH
`define REACTION_DIFFUSION_CELL_UPDATE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RDCU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RDCU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rdcu_pkg.sv -----
// Package of the reaction-diffusion cell update: formats, reset values,
// register codes and the stage bundles passed between modules. No dependencies.
`default_nettype none

package rdcu_pkg;

  localparam int ValW     = 24;
  localparam int FracBits = 20;
  localparam int CfgIdxW  = 3;
  localparam int NumW     = 52;
  localparam int DenW     = 25;
  localparam int LogW     = 29;
  localparam int LapW     = 27;
  localparam int LapTermW = 31;
  localparam int KinW     = 54;
  localparam int DivStages = NumW;

  localparam logic [ValW-1:0] ValMax    = {ValW{1'b1}};
  localparam logic [ValW-1:0] OneVal    = ValW'(64'd1 << FracBits);
  localparam logic [ValW-1:0] StoichRst = 24'd1310720;
  localparam logic [ValW-1:0] ExcitRst  = 24'd2097;

  typedef enum logic [CfgIdxW-1:0] {
    RegTimeStep,
    RegKineticGain,
    RegActDiff,
    RegReactDiff,
    RegStoich,
    RegExcit
  } cfg_reg_e;

  typedef struct packed {
    logic [ValW-1:0] time_step;
    logic [ValW-1:0] kinetic_gain;
    logic [ValW-1:0] act_diff;
    logic [ValW-1:0] react_diff;
    logic [ValW-1:0] stoich;
    logic [ValW-1:0] excit;
  } cfg_t;

  // One slot of the divider pipeline; nq holds the remaining dividend bits
  // on top and the quotient bits collected so far at the bottom.
  typedef struct packed {
    logic                       valid;
    logic [NumW-1:0]            nq;
    logic [DenW-1:0]            rem;
    logic [DenW-1:0]            den;
    logic                       neg;
    logic signed [LogW-1:0]     logistic;
    logic [ValW-1:0]            p;
    logic signed [LapTermW-1:0] lapx_term;
    logic [ValW-1:0]            y_res;
    logic [ValW-1:0]            r_res;
  } div_t;

  // Clamp at zero and saturate at the format maximum.
  function automatic logic [ValW-1:0] clamp_val(input logic signed [63:0] v);
    logic [ValW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({40'd0, ValMax})) begin
      res = ValMax;
    end else begin
      res = v[ValW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/rdcu_front.sv -----
// Front four stages: spot forcing, Laplacians, x*r, f*y, p*p, y and r results,
// and the numerator and denominator of the rational term. Uses rdcu_pkg.
`default_nettype none

module rdcu_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire rdcu_pkg::cfg_t                 cfg_i,
  input  wire logic                           valid_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      x_center_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      x_west_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      x_east_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      x_north_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      x_south_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      r_center_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      r_west_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      r_east_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      r_north_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      r_south_i,
  input  wire logic [rdcu_pkg::ValW-1:0]      y_center_i,
  input  wire logic                           is_spot_i,
  output rdcu_pkg::div_t                      div_o
);

  logic [3:0] v_q;

  // Stage 1
  logic [47:0] s1_xr_q, s1_fy_q;
  logic signed [rdcu_pkg::LapW-1:0] s1_lapx_q, s1_lapr_q, s1_lapx_d, s1_lapr_d;
  logic [rdcu_pkg::ValW-1:0] s1_yc_q, s1_rc_q, rc_d;

  // Stage 2
  logic [rdcu_pkg::ValW-1:0] s2_p_q, s2_yc_q, s2_rc_q, p_d;
  logic [27:0] s2_fy_q;
  logic signed [51:0] s2_lapx_q, s2_lapr_q;
  logic [47:0] xr_sh, fy_sh;

  // Stage 3
  logic [47:0] s3_pp_q;
  logic [rdcu_pkg::ValW-1:0] s3_p_q, s3_absd_q, s3_yc_q, s3_r_q;
  logic s3_neg_q;
  logic [rdcu_pkg::DenW-1:0] s3_den_q;
  logic [27:0] s3_fy_q;
  logic signed [rdcu_pkg::LapTermW-1:0] s3_lapx_q;
  logic signed [49:0] s3_ymul_q;
  logic signed [51:0] lapr_sh, lapx_sh;

  // Stage 4
  logic [rdcu_pkg::NumW-1:0] s4_num_q;
  logic signed [rdcu_pkg::LogW-1:0] s4_log_q;
  logic [rdcu_pkg::ValW-1:0] s4_p_q, s4_y_q, s4_r_q;
  logic s4_neg_q;
  logic [rdcu_pkg::DenW-1:0] s4_den_q;
  logic signed [rdcu_pkg::LapTermW-1:0] s4_lapx_q;
  logic [47:0] pp_sh;
  logic signed [49:0] ymul_sh;

  assign rc_d = is_spot_i ? rdcu_pkg::OneVal : r_center_i;
  assign s1_lapx_d = $signed({3'd0, x_west_i}) + $signed({3'd0, x_east_i})
                   + $signed({3'd0, x_north_i}) + $signed({3'd0, x_south_i})
                   - $signed({1'b0, x_center_i, 2'b00});
  assign s1_lapr_d = $signed({3'd0, r_west_i}) + $signed({3'd0, r_east_i})
                   + $signed({3'd0, r_north_i}) + $signed({3'd0, r_south_i})
                   - $signed({1'b0, rc_d, 2'b00});

  assign xr_sh = s1_xr_q >> rdcu_pkg::FracBits;
  assign fy_sh = s1_fy_q >> rdcu_pkg::FracBits;
  assign p_d   = (|xr_sh[47:24]) ? rdcu_pkg::ValMax : xr_sh[23:0];

  assign lapx_sh = s2_lapx_q >>> rdcu_pkg::FracBits;
  assign lapr_sh = s2_lapr_q >>> rdcu_pkg::FracBits;

  assign pp_sh   = s3_pp_q >> rdcu_pkg::FracBits;
  assign ymul_sh = s3_ymul_q >>> rdcu_pkg::FracBits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_xr_q   <= 48'(x_center_i) * 48'(rc_d);
      s1_fy_q   <= 48'(cfg_i.stoich) * 48'(y_center_i);
      s1_lapx_q <= s1_lapx_d;
      s1_lapr_q <= s1_lapr_d;
      s1_yc_q   <= y_center_i;
      s1_rc_q   <= rc_d;

      s2_p_q    <= p_d;
      s2_fy_q   <= fy_sh[27:0];
      s2_lapx_q <= 52'(s1_lapx_q) * 52'($signed({1'b0, cfg_i.act_diff}));
      s2_lapr_q <= 52'(s1_lapr_q) * 52'($signed({1'b0, cfg_i.react_diff}));
      s2_yc_q   <= s1_yc_q;
      s2_rc_q   <= s1_rc_q;

      s3_pp_q   <= 48'(s2_p_q) * 48'(s2_p_q);
      s3_p_q    <= s2_p_q;
      s3_neg_q  <= s2_p_q < cfg_i.excit;
      s3_absd_q <= (s2_p_q < cfg_i.excit) ? cfg_i.excit - s2_p_q : s2_p_q - cfg_i.excit;
      s3_den_q  <= rdcu_pkg::DenW'(s2_p_q) + rdcu_pkg::DenW'(cfg_i.excit);
      s3_fy_q   <= s2_fy_q;
      s3_lapx_q <= lapx_sh[rdcu_pkg::LapTermW-1:0];
      s3_yc_q   <= s2_yc_q;
      s3_r_q    <= rdcu_pkg::clamp_val($signed({40'd0, s2_rc_q}) + 64'(lapr_sh));
      s3_ymul_q <= 50'($signed({1'b0, s2_p_q}) - $signed({1'b0, s2_yc_q}))
                 * 50'($signed({1'b0, cfg_i.time_step}));

      s4_log_q  <= $signed({5'd0, s3_p_q}) - $signed({1'b0, pp_sh[27:0]});
      s4_num_q  <= rdcu_pkg::NumW'(s3_fy_q) * rdcu_pkg::NumW'(s3_absd_q);
      s4_p_q    <= s3_p_q;
      s4_neg_q  <= s3_neg_q;
      s4_den_q  <= s3_den_q;
      s4_lapx_q <= s3_lapx_q;
      s4_y_q    <= rdcu_pkg::clamp_val($signed({40'd0, s3_yc_q}) + 64'(ymul_sh));
      s4_r_q    <= s3_r_q;
    end
  end

  always_comb begin
    div_o           = '0;
    div_o.valid     = v_q[3];
    div_o.nq        = s4_num_q;
    div_o.rem       = '0;
    div_o.den       = s4_den_q;
    div_o.neg       = s4_neg_q;
    div_o.logistic  = s4_log_q;
    div_o.p         = s4_p_q;
    div_o.lapx_term = s4_lapx_q;
    div_o.y_res     = s4_y_q;
    div_o.r_res     = s4_r_q;
  end

endmodule

`default_nettype wire

// ----- src/rdcu_div_stage.sv -----
// One restoring-division step: one quotient bit per stage, payload carried along.
// Uses rdcu_pkg.
`default_nettype none

module rdcu_div_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire rdcu_pkg::div_t d_i,
  output rdcu_pkg::div_t      d_o
);

  logic [rdcu_pkg::DenW:0] rem_ext, rem_sub;
  logic ge;
  rdcu_pkg::div_t data_d, data_q;
  logic valid_q;

  assign rem_ext = {d_i.rem, d_i.nq[rdcu_pkg::NumW-1]};
  assign ge      = rem_ext >= {1'b0, d_i.den};
  assign rem_sub = rem_ext - {1'b0, d_i.den};

  always_comb begin
    data_d     = d_i;
    data_d.rem = ge ? rem_sub[rdcu_pkg::DenW-1:0] : rem_ext[rdcu_pkg::DenW-1:0];
    data_d.nq  = {d_i.nq[rdcu_pkg::NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    d_o       = data_q;
    d_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ----- src/rdcu_back.sv -----
// Back three stages: signed rational term and kinetics, split kinetic-gain
// product, and the output register with the activator sum. Uses rdcu_pkg.
`default_nettype none

module rdcu_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire rdcu_pkg::cfg_t            cfg_i,
  input  wire rdcu_pkg::div_t            d_i,
  output logic                           valid_o,
  output logic [rdcu_pkg::ValW-1:0]      x_next_o,
  output logic [rdcu_pkg::ValW-1:0]      y_next_o,
  output logic [rdcu_pkg::ValW-1:0]      r_next_o
);

  logic [2:0] v_q;
  logic signed [rdcu_pkg::NumW:0] rational;
  logic signed [rdcu_pkg::KinW-1:0] ka_kin_q;
  logic [rdcu_pkg::ValW-1:0] ka_p_q, ka_y_q, ka_r_q, kb_p_q, kb_y_q, kb_r_q;
  logic signed [rdcu_pkg::LapTermW-1:0] ka_lapx_q, kb_lapx_q;
  logic [50:0] kb_lo_q;
  logic signed [51:0] kb_hi_q;
  logic signed [78:0] full;
  logic signed [78:0] term;
  logic signed [63:0] x_sum;
  logic [rdcu_pkg::ValW-1:0] x_q, y_q, r_q;

  always_comb begin
    if (d_i.den == '0) begin
      rational = '0;
    end else if (d_i.neg) begin
      rational = -$signed({1'b0, d_i.nq});
    end else begin
      rational = $signed({1'b0, d_i.nq});
    end
  end

  // The kinetics value is wider than one multiplier, so it is split in a low
  // unsigned half and a high signed half and recombined in the output stage.
  assign full  = (79'(kb_hi_q) <<< 27) + $signed({28'd0, kb_lo_q});
  assign term  = full >>> rdcu_pkg::FracBits;
  assign x_sum = $signed({40'd0, kb_p_q}) + 64'(term) + 64'(kb_lapx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], d_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ka_kin_q  <= rdcu_pkg::KinW'(d_i.logistic) - rdcu_pkg::KinW'(rational);
      ka_p_q    <= d_i.p;
      ka_lapx_q <= d_i.lapx_term;
      ka_y_q    <= d_i.y_res;
      ka_r_q    <= d_i.r_res;

      kb_lo_q   <= 51'(ka_kin_q[26:0]) * 51'(cfg_i.kinetic_gain);
      kb_hi_q   <= 52'($signed(ka_kin_q[rdcu_pkg::KinW-1:27]))
                 * 52'($signed({1'b0, cfg_i.kinetic_gain}));
      kb_p_q    <= ka_p_q;
      kb_lapx_q <= ka_lapx_q;
      kb_y_q    <= ka_y_q;
      kb_r_q    <= ka_r_q;

      x_q       <= rdcu_pkg::clamp_val(x_sum);
      y_q       <= kb_y_q;
      r_q       <= kb_r_q;
    end
  end

  assign valid_o  = v_q[2];
  assign x_next_o = x_q;
  assign y_next_o = y_q;
  assign r_next_o = r_q;

endmodule

`default_nettype wire

// ----- src/reaction_diffusion_cell_update.sv -----
// Reaction-diffusion cell update, top level: registers, front, divider, back.
// The pipeline has 4 front stages, 52 divider stages and 3 back stages.
// Throughput is one point per cycle; the whole pipeline holds while a result is stalled.
// The 52-stage quotient pipeline of the rational term sets the latency.
// Reset clears all valid bits and loads the register defaults (f = 1.25, q = 0.002).
`default_nettype none

module reaction_diffusion_cell_update (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [rdcu_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [rdcu_pkg::ValW-1:0]            x_center_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            x_west_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            x_east_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            x_north_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            x_south_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            r_center_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            r_west_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            r_east_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            r_north_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            r_south_i,
  input  wire logic [rdcu_pkg::ValW-1:0]            y_center_i,
  input  wire logic                                 is_spot_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [rdcu_pkg::ValW-1:0]                 x_next_o,
  output logic [rdcu_pkg::ValW-1:0]                 y_next_o,
  output logic [rdcu_pkg::ValW-1:0]                 r_next_o
);

  rdcu_pkg::cfg_t cfg_q;
  rdcu_pkg::div_t div_s [rdcu_pkg::DivStages+1];
  logic en;

  // Every stage moves together unless a result sits stalled at the output.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step    <= '0;
      cfg_q.kinetic_gain <= '0;
      cfg_q.act_diff     <= '0;
      cfg_q.react_diff   <= '0;
      cfg_q.stoich       <= rdcu_pkg::StoichRst;
      cfg_q.excit        <= rdcu_pkg::ExcitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rdcu_pkg::cfg_reg_e'(cfg_index_i))
        rdcu_pkg::RegTimeStep:    cfg_q.time_step    <= cfg_data_i;
        rdcu_pkg::RegKineticGain: cfg_q.kinetic_gain <= cfg_data_i;
        rdcu_pkg::RegActDiff:     cfg_q.act_diff     <= cfg_data_i;
        rdcu_pkg::RegReactDiff:   cfg_q.react_diff   <= cfg_data_i;
        rdcu_pkg::RegStoich:      cfg_q.stoich       <= cfg_data_i;
        rdcu_pkg::RegExcit:       cfg_q.excit        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rdcu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .valid_i    (in_valid_i),
    .x_center_i (x_center_i),
    .x_west_i   (x_west_i),
    .x_east_i   (x_east_i),
    .x_north_i  (x_north_i),
    .x_south_i  (x_south_i),
    .r_center_i (r_center_i),
    .r_west_i   (r_west_i),
    .r_east_i   (r_east_i),
    .r_north_i  (r_north_i),
    .r_south_i  (r_south_i),
    .y_center_i (y_center_i),
    .is_spot_i  (is_spot_i),
    .div_o      (div_s[0])
  );

  for (genvar i = 0; i < rdcu_pkg::DivStages; i++) begin : g_div
    rdcu_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (div_s[i]),
      .d_o    (div_s[i+1])
    );
  end

  rdcu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .d_i      (div_s[rdcu_pkg::DivStages]),
    .valid_o  (out_valid_o),
    .x_next_o (x_next_o),
    .y_next_o (y_next_o),
    .r_next_o (r_next_o)
  );

endmodule

`default_nettype wire

// ----- src/rdcu_checker.sv -----
// Port-level checker for the reaction-diffusion cell update and its bind.
// Uses the macros of reaction_diffusion_cell_update_assert.svh and rdcu_pkg.
`default_nettype none
`include "reaction_diffusion_cell_update_assert.svh"

module rdcu_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_valid_i,
  input wire logic                         cfg_ready_o,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [rdcu_pkg::ValW-1:0]    x_next_o,
  input wire logic [rdcu_pkg::ValW-1:0]    y_next_o,
  input wire logic [rdcu_pkg::ValW-1:0]    r_next_o
);

  // A stalled result stays put until it is taken.
  `RDCU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(x_next_o) && $stable(y_next_o) && $stable(r_next_o), "stalled result changed")

  // Input requests are held back only by a stalled result.
  `RDCU_ASSERT_IMP(a_stall_src, 1'b1, in_stall_o == (out_valid_o && out_stall_i), "input stall without a stalled result")

  // Register writes are never refused.
  `RDCU_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o, "register write refused")

endmodule

bind reaction_diffusion_cell_update rdcu_checker u_rdcu_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench of the reaction-diffusion cell update.
// Drives random and corner-case points, predicts each result in place and checks it;
// depends on rdcu_pkg and reaction_diffusion_cell_update.
`timescale 1ns / 1ps

module tb;

  localparam logic [rdcu_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int SegItems = 75;
  localparam int NumSegs = 7;
  localparam int DrainCycles = 70;

  typedef struct packed {
    logic [rdcu_pkg::ValW-1:0] x_center, x_west, x_east, x_north, x_south;
    logic [rdcu_pkg::ValW-1:0] r_center, r_west, r_east, r_north, r_south;
    logic [rdcu_pkg::ValW-1:0] y_center;
    logic                      is_spot;
  } grid_point_t;

  typedef struct packed {
    logic [rdcu_pkg::ValW-1:0] x_next, y_next, r_next;
  } cell_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rdcu_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [rdcu_pkg::ValW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  grid_point_t drive_point = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [rdcu_pkg::ValW-1:0] x_next_o, y_next_o, r_next_o;

  rdcu_pkg::cfg_t cfg_shadow;
  grid_point_t pending_points[$];
  cell_state_t expected_cells[$];
  bit feed_enable = 1'b0;
  bit point_taken = 1'b0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int errors = 0;

  reaction_diffusion_cell_update i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .x_center_i(drive_point.x_center), .x_west_i(drive_point.x_west),
    .x_east_i(drive_point.x_east), .x_north_i(drive_point.x_north),
    .x_south_i(drive_point.x_south), .r_center_i(drive_point.r_center),
    .r_west_i(drive_point.r_west), .r_east_i(drive_point.r_east),
    .r_north_i(drive_point.r_north), .r_south_i(drive_point.r_south),
    .y_center_i(drive_point.y_center), .is_spot_i(drive_point.is_spot),
    .out_valid_o, .out_stall_i, .x_next_o, .y_next_o, .r_next_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [rdcu_pkg::ValW-1:0] clamp_to_format(longint v);
    logic [rdcu_pkg::ValW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > longint'(rdcu_pkg::ValMax)) begin
      res = rdcu_pkg::ValMax;
    end else begin
      res = v[rdcu_pkg::ValW-1:0];
    end
    return res;
  endfunction

  // Euler step of one grid point; products are floored by arithmetic shifts.
  function automatic cell_state_t step_cell(grid_point_t pt, rdcu_pkg::cfg_t c);
    cell_state_t res;
    longint rc, p, q, fy, logistic, rational, num, den, kin, lapx, lapr;
    longint xn, yn, rn;
    rc = pt.is_spot ? longint'(rdcu_pkg::OneVal) : longint'(pt.r_center);
    p = (longint'(pt.x_center) * rc) >>> rdcu_pkg::FracBits;
    if (p > longint'(rdcu_pkg::ValMax)) p = rdcu_pkg::ValMax;
    q = c.excit;
    logistic = p - ((p * p) >>> rdcu_pkg::FracBits);
    fy = (longint'(c.stoich) * longint'(pt.y_center)) >>> rdcu_pkg::FracBits;
    num = fy * (p - q);
    den = p + q;
    rational = (den == 0) ? 0 : num / den;
    kin = logistic - rational;
    lapx = longint'(pt.x_west) + pt.x_east + pt.x_north + pt.x_south
           - 4 * longint'(pt.x_center);
    lapr = longint'(pt.r_west) + pt.r_east + pt.r_north + pt.r_south - 4 * rc;
    xn = p + ((kin * longint'(c.kinetic_gain)) >>> rdcu_pkg::FracBits)
           + ((lapx * longint'(c.act_diff)) >>> rdcu_pkg::FracBits);
    yn = longint'(pt.y_center)
         + (((p - longint'(pt.y_center)) * longint'(c.time_step)) >>> rdcu_pkg::FracBits);
    rn = rc + ((lapr * longint'(c.react_diff)) >>> rdcu_pkg::FracBits);
    res.x_next = clamp_to_format(xn);
    res.y_next = clamp_to_format(yn);
    res.r_next = clamp_to_format(rn);
    return res;
  endfunction

  function automatic logic [rdcu_pkg::ValW-1:0] pick_value();
    logic [rdcu_pkg::ValW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = rdcu_pkg::ValMax;
      2, 3: v = rdcu_pkg::ValW'($urandom());
      default: v = rdcu_pkg::ValW'($urandom_range(0, 1 << 21));
    endcase
    return v;
  endfunction

  function automatic grid_point_t random_point();
    grid_point_t pt;
    pt.x_center = pick_value();
    pt.x_west = pick_value();
    pt.x_east = pick_value();
    pt.x_north = pick_value();
    pt.x_south = pick_value();
    pt.r_center = pick_value();
    pt.r_west = pick_value();
    pt.r_east = pick_value();
    pt.r_north = pick_value();
    pt.r_south = pick_value();
    pt.y_center = pick_value();
    pt.is_spot = 1'($urandom_range(0, 1));
    return pt;
  endfunction

  // Inputs move on the falling edge; a held request keeps its payload.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
    if (!in_valid_i || point_taken) begin
      if (feed_enable && pending_points.size() != 0
          && $urandom_range(0, 99) >= in_idle_pct) begin
        drive_point <= pending_points.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cell_state_t exp_cell;
    point_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      expected_cells.push_back(step_cell(drive_point, cfg_shadow));
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result x=%0d y=%0d r=%0d", x_next_o, y_next_o, r_next_o);
        errors++;
      end else begin
        exp_cell = expected_cells.pop_front();
        if (x_next_o !== exp_cell.x_next) begin
          $error("x_next expected %0d actual %0d", exp_cell.x_next, x_next_o);
          errors++;
        end
        if (y_next_o !== exp_cell.y_next) begin
          $error("y_next expected %0d actual %0d", exp_cell.y_next, y_next_o);
          errors++;
        end
        if (r_next_o !== exp_cell.r_next) begin
          $error("r_next expected %0d actual %0d", exp_cell.r_next, r_next_o);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [rdcu_pkg::CfgIdxW-1:0] idx,
                           logic [rdcu_pkg::ValW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      rdcu_pkg::RegTimeStep: cfg_shadow.time_step = value;
      rdcu_pkg::RegKineticGain: cfg_shadow.kinetic_gain = value;
      rdcu_pkg::RegActDiff: cfg_shadow.act_diff = value;
      rdcu_pkg::RegReactDiff: cfg_shadow.react_diff = value;
      rdcu_pkg::RegStoich: cfg_shadow.stoich = value;
      rdcu_pkg::RegExcit: cfg_shadow.excit = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends the queued points and waits until every result has come back.
  task automatic run_points();
    feed_enable = 1'b1;
    wait (pending_points.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    feed_enable = 1'b0;
    wait (expected_cells.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic logic [rdcu_pkg::ValW-1:0] pick_reg_value(int mode);
    logic [rdcu_pkg::ValW-1:0] v;
    case (mode)
      0: v = '0;
      1: v = rdcu_pkg::ValMax;
      default: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = rdcu_pkg::ValMax;
          2: v = rdcu_pkg::ValW'($urandom());
          default: v = rdcu_pkg::ValW'($urandom_range(0, 1 << 20));
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    grid_point_t pt;
    int mode;
    cfg_shadow = '{time_step: '0, kinetic_gain: '0, act_diff: '0, react_diff: '0,
                   stoich: rdcu_pkg::StoichRst, excit: rdcu_pkg::ExcitRst};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: gains are zero, so only the product and forcing show.
    repeat (10) pending_points.push_back(random_point());
    run_points();

    write_reg(rdcu_pkg::RegTimeStep, 24'd104858);
    write_reg(rdcu_pkg::RegKineticGain, 24'd1048576);
    write_reg(rdcu_pkg::RegActDiff, 24'd209715);
    write_reg(rdcu_pkg::RegReactDiff, 24'd104858);
    write_reg(RegUnused, rdcu_pkg::ValW'($urandom()));

    pt = '0;
    pending_points.push_back(pt);
    pt = '1;
    pending_points.push_back(pt);
    pt.is_spot = 1'b0;
    pending_points.push_back(pt);
    // Center peak with empty neighbours drives both Laplacians far negative.
    pt = '0;
    pt.x_center = rdcu_pkg::ValMax;
    pt.r_center = rdcu_pkg::ValMax;
    pending_points.push_back(pt);
    // Empty center with full neighbours saturates upward.
    pt = '1;
    pt.x_center = '0;
    pt.r_center = '0;
    pt.is_spot = 1'b0;
    pending_points.push_back(pt);
    pt.is_spot = 1'b1;
    pending_points.push_back(pt);
    // Large inhibitor with small product makes the rational term dominate.
    pt = '0;
    pt.x_center = 24'd1;
    pt.r_center = 24'd1;
    pt.y_center = rdcu_pkg::ValMax;
    pending_points.push_back(pt);
    pt.x_center = 24'd1048576;
    pt.is_spot = 1'b1;
    pending_points.push_back(pt);
    repeat (6) pending_points.push_back(random_point());
    run_points();

    // Zero offset: a zero product hits the zero-denominator rule.
    write_reg(rdcu_pkg::RegExcit, '0);
    pt = '0;
    pt.y_center = rdcu_pkg::ValMax;
    pending_points.push_back(pt);
    pt.r_center = rdcu_pkg::ValMax;
    pending_points.push_back(pt);
    pt.is_spot = 1'b1;
    pending_points.push_back(pt);
    pt = '1;
    pending_points.push_back(pt);
    run_points();

    for (int seg = 0; seg < NumSegs; seg++) begin
      if (seg < 2) begin
        in_idle_pct = 7;
        out_idle_pct = 75;
      end else if (seg < 4) begin
        in_idle_pct = 75;
        out_idle_pct = 7;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      mode = (seg == 1) ? 0 : (seg == 3) ? 1 : 2;
      for (int r = 0; r <= rdcu_pkg::RegExcit; r++) begin
        write_reg(r[rdcu_pkg::CfgIdxW-1:0], pick_reg_value(mode));
      end
      repeat (SegItems) pending_points.push_back(random_point());
      run_points();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
